[hdl/chmd_pkg.sv]
// ----------------------------------------------------------------------------
// chmd_pkg
// Shared types and codes for the conservative height-map min downsampler.
// ----------------------------------------------------------------------------
package chmd_pkg;
    localparam int MAX_SIDE = 65;
    localparam int HW = 24;
    localparam int IDXW = 13;
    localparam int SIDEW = 7;
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_FETCH = 1'b1;
    localparam logic [0:0] REG_LOD = 1'b0;
    localparam logic [0:0] REG_SIDE = 1'b1;
    typedef logic signed [HW-1:0] t_height;
endpackage

[hdl/conservative_heightmap_min_downsample.sv]
// ----------------------------------------------------------------------------
// conservative_heightmap_min_downsample
// Loads a square height grid, pools coarse quad minima into a memory and
// reads out coarse vertices with their conservative minimum height.
// ----------------------------------------------------------------------------
// channel | direction | handshake
// request | in        | i_valid / o_ready, fields i_func, i_height
// result  | out       | o_valid / i_ready, ten result fields
// config  | in        | i_cfg_we, i_cfg_index, i_cfg_data
//
// A load writes one sample into the sample memory; loads can follow back to
// back. The load that completes the grid starts a pooling pass when the
// coarse side is at least two: every quad window sample is read one a cycle
// from the sample memory, and after each quad's last read the write state
// drains that read and writes the quad minimum.
// A fetch first splits its index into row and column by subtracting the
// coarse side once a cycle, then reads four quad slots one a cycle and
// registers the result, which raises o_valid. Requests are refused while
// pooling or fetching, or while a result waits in the output register.
// Reset is synchronous and resets control and configuration state only;
// memories hold whatever was written.
// ----------------------------------------------------------------------------
module conservative_heightmap_min_downsample (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic [0:0] i_cfg_index,
    input  logic [6:0] i_cfg_data,
    input  logic i_valid,
    output logic o_ready,
    input  logic i_func,
    input  logic signed [23:0] i_height,
    output logic o_valid,
    input  logic i_ready,
    output logic o_status,
    output logic [6:0] o_vertex_col,
    output logic [6:0] o_vertex_row,
    output logic signed [23:0] o_vertex_height,
    output logic o_has_quad,
    output logic [12:0] o_corner_tl,
    output logic [12:0] o_corner_tr,
    output logic [12:0] o_corner_bl,
    output logic [12:0] o_corner_br,
    output logic o_last_vertex
);
    import chmd_pkg::*;

    localparam int HD = MAX_SIDE * MAX_SIDE;
    localparam int QD = (MAX_SIDE - 1) * (MAX_SIDE - 1);
    localparam int HAW = $clog2(HD);
    localparam int QAW = $clog2(QD);
    localparam int SW = $clog2(MAX_SIDE + 1);
    localparam int CW = HAW + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_POOL = 3'd1;
    localparam logic [2:0] S_PWR = 3'd2;
    localparam logic [2:0] S_FETCH = 3'd3;
    localparam logic [2:0] S_FDONE = 3'd4;

    // configuration
    logic [2:0] r_lod;
    logic [6:0] r_side;
    // control
    logic [2:0] r_state;
    logic [CW-1:0] r_load_cnt, r_fetch_cnt;
    logic r_ready_g;
    // pooling walk
    logic [SW-1:0] r_qi, r_qj, r_fi, r_fj;
    logic r_rd_v, r_first;
    t_height r_min;
    // fetch walk
    logic [2:0] r_k;
    logic [SW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic r_have;
    // output
    logic r_ov;
    logic r_st, r_hq, r_last;
    logic [6:0] r_ocol, r_orow;
    t_height r_oh;
    logic [12:0] r_tl, r_tr, r_bl, r_br;

    t_height hmem [HD];
    t_height qmem [QD];
    t_height r_hrd, r_qrd;

    // effective side and coarse side
    logic [SW-1:0] n_eff, cs, q, step;
    logic [SW+6:0] cs_tmp;
    always_comb begin
        n_eff = (r_side > 7'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(r_side);
        step = SW'(1) << r_lod;
        cs_tmp = (SW+7)'(n_eff - SW'(1)) >> r_lod;
        if (n_eff < SW'(2)) cs = n_eff;
        else cs = SW'(cs_tmp) + SW'(1);
        q = cs - SW'(1);
    end
    logic [CW-1:0] total, cs2;
    assign total = CW'(n_eff) * CW'(n_eff);
    assign cs2 = CW'(cs) * CW'(cs);

    wire acc = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE) && !r_ov;

    // pooling window ends, clamped at the grid edge
    logic [SW+6:0] ei_w, ej_w;
    logic [SW-1:0] ei, ej, ws_i, ws_j;
    always_comb begin
        ws_i = SW'((SW+7)'(r_qi) << r_lod);
        ws_j = SW'((SW+7)'(r_qj) << r_lod);
        ei_w = ((SW+7)'(r_qi) + (SW+7)'(1)) << r_lod;
        ej_w = ((SW+7)'(r_qj) + (SW+7)'(1)) << r_lod;
        ei = (ei_w > (SW+7)'(n_eff - SW'(1))) ? n_eff - SW'(1) : SW'(ei_w);
        ej = (ej_w > (SW+7)'(n_eff - SW'(1))) ? n_eff - SW'(1) : SW'(ej_w);
    end

    logic [HAW-1:0] h_raddr;
    assign h_raddr = HAW'(CW'(r_fj) * CW'(n_eff) + CW'(r_fi));
    logic [QAW-1:0] q_waddr;
    assign q_waddr = QAW'(CW'(r_qj) * CW'(q) + CW'(r_qi));

    // fetch neighbor quad: k = dj*2+di
    logic [SW:0] nj, ni;
    logic nb_ok;
    logic [QAW-1:0] q_raddr;
    always_comb begin
        nj = (SW+1)'(r_row) + (SW+1)'(r_k[1]);
        ni = (SW+1)'(r_col) + (SW+1)'(r_k[0]);
        nb_ok = (nj != '0) && (ni != '0) &&
                (nj - (SW+1)'(1) < (SW+1)'(q)) && (ni - (SW+1)'(1) < (SW+1)'(q));
        q_raddr = QAW'(CW'(nj - (SW+1)'(1)) * CW'(q) + CW'(ni - (SW+1)'(1)));
    end
    logic r_nb_v;

    wire pool_last_sample = (r_fi == ei) && (r_fj == ej);
    wire h_new_lt = r_first || (r_hrd < r_min);
    t_height min_now;
    assign min_now = h_new_lt ? r_hrd : r_min;

    // memories
    always_ff @(posedge i_clk) begin
        if (acc && i_func == FUNC_LOAD && !r_ready_g && r_load_cnt < total)
            hmem[HAW'(r_load_cnt)] <= i_height;
        else if (acc && i_func == FUNC_LOAD && r_ready_g && total != '0)
            hmem[0] <= i_height;
        r_hrd <= hmem[h_raddr];
        if (r_state == S_PWR) qmem[q_waddr] <= r_min;
        r_qrd <= qmem[q_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lod <= '0; r_side <= 7'(MAX_SIDE); r_state <= S_IDLE;
            r_load_cnt <= '0; r_fetch_cnt <= '0; r_ready_g <= 1'b0;
            r_ov <= 1'b0; r_rd_v <= 1'b0; r_nb_v <= 1'b0;
        end else begin
            if (r_ov && i_ready) r_ov <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_LOD: r_lod <= i_cfg_data[2:0];
                    REG_SIDE: r_side <= i_cfg_data;
                    default: ;
                endcase
                r_load_cnt <= '0; r_fetch_cnt <= '0; r_ready_g <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (acc && i_func == FUNC_LOAD) begin
                        logic [CW-1:0] lc;
                        lc = r_ready_g ? '0 : r_load_cnt;
                        if (r_ready_g) begin
                            r_ready_g <= 1'b0; r_fetch_cnt <= '0;
                        end
                        if (lc < total) begin
                            r_load_cnt <= lc + CW'(1);
                            if (lc + CW'(1) == total) begin
                                r_ready_g <= 1'b1; r_fetch_cnt <= '0;
                                if (cs >= SW'(2)) begin
                                    r_state <= S_POOL;
                                    r_qi <= '0; r_qj <= '0; r_fi <= '0; r_fj <= '0;
                                    r_first <= 1'b1; r_rd_v <= 1'b0;
                                end
                            end
                        end else r_load_cnt <= lc;
                    end else if (acc) begin
                        if (!r_ready_g || cs < SW'(2)) begin
                            r_ov <= 1'b1; r_st <= 1'b1; r_ocol <= '0; r_orow <= '0;
                            r_oh <= '0; r_hq <= 1'b0; r_tl <= '0; r_tr <= '0;
                            r_bl <= '0; r_br <= '0; r_last <= 1'b0;
                        end else begin
                            logic [CW-1:0] fc;
                            fc = (r_fetch_cnt >= cs2) ? '0 : r_fetch_cnt;
                            r_fetch_cnt <= fc;
                            // split index with a short subtract walk
                            r_row <= '0; r_col <= fc;
                            r_k <= '0; r_have <= 1'b0; r_nb_v <= 1'b0;
                            r_state <= S_FETCH;
                            r_first <= 1'b1;
                        end
                    end
                end
                S_POOL: begin
                    // issue read of (fi,fj); consume previous read
                    r_rd_v <= 1'b1;
                    if (r_rd_v) begin
                        r_min <= min_now; r_first <= 1'b0;
                    end
                    if (pool_last_sample) r_state <= S_PWR;
                    else if (r_fi == ei) begin
                        r_fi <= ws_i; r_fj <= r_fj + SW'(1);
                    end else r_fi <= r_fi + SW'(1);
                end
                S_PWR: begin
                    // drain last read, then write quad
                    if (r_rd_v) begin
                        r_min <= min_now; r_rd_v <= 1'b0;
                        r_state <= S_PWR;
                    end else begin
                        r_first <= 1'b1;
                        if (r_qi == q - SW'(1)) begin
                            if (r_qj == q - SW'(1)) r_state <= S_IDLE;
                            else begin
                                r_qi <= '0; r_qj <= r_qj + SW'(1);
                                r_fi <= '0;
                                r_fj <= SW'((SW+7)'(r_qj + SW'(1)) << r_lod);
                                r_state <= S_POOL;
                            end
                        end else begin
                            r_qi <= r_qi + SW'(1);
                            r_fi <= ws_i + step; r_fj <= ws_j;
                            r_state <= S_POOL;
                        end
                    end
                end
                S_FETCH: begin
                    if (r_first) begin
                        // row/col split: subtract cs per cycle
                        if (r_col >= CW'(cs)) begin
                            r_col <= r_col - CW'(cs); r_row <= r_row + SW'(1);
                        end else r_first <= 1'b0;
                    end else begin
                        r_nb_v <= (r_k != 3'd4) && nb_ok;
                        if (r_nb_v && (!r_have || r_qrd < r_oh)) begin
                            r_oh <= r_qrd;
                        end
                        if (r_nb_v) r_have <= 1'b1;
                        if (r_k == 3'd4) r_state <= S_FDONE;
                        else r_k <= r_k + 3'd1;
                    end
                end
                S_FDONE: begin
                    logic [CW-1:0] tl;
                    tl = r_fetch_cnt;
                    if (r_nb_v && (!r_have || r_qrd < r_oh)) r_oh <= r_qrd;
                    else if (!r_have && !r_nb_v) r_oh <= '0;
                    r_nb_v <= 1'b0;
                    r_ov <= 1'b1; r_st <= 1'b0;
                    r_ocol <= 7'(r_col); r_orow <= 7'(r_row);
                    r_hq <= (r_row < q) && (r_col < CW'(q));
                    if ((r_row < q) && (r_col < CW'(q))) begin
                        r_tl <= 13'(tl); r_tr <= 13'(tl + CW'(1));
                        r_bl <= 13'(tl + CW'(cs)); r_br <= 13'(tl + CW'(cs) + CW'(1));
                    end else begin
                        r_tl <= '0; r_tr <= '0; r_bl <= '0; r_br <= '0;
                    end
                    r_last <= (tl == cs2 - CW'(1));
                    r_fetch_cnt <= (tl == cs2 - CW'(1)) ? '0 : tl + CW'(1);
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_ov;
    assign o_status = r_st;
    assign o_vertex_col = r_ocol;
    assign o_vertex_row = r_orow;
    assign o_vertex_height = r_oh;
    assign o_has_quad = r_hq;
    assign o_corner_tl = r_tl;
    assign o_corner_tr = r_tr;
    assign o_corner_bl = r_bl;
    assign o_corner_br = r_br;
    assign o_last_vertex = r_last;
endmodule

[hdl/chmd_checker.sv]
// ----------------------------------------------------------------------------
// chmd_checker
// Port-level checks for the height-map downsampler.
// ----------------------------------------------------------------------------
module chmd_checker (
    input logic i_clk, input logic i_rst_n,
    input logic i_valid, input logic o_ready,
    input logic o_valid, input logic i_ready,
    input logic o_status, input logic o_has_quad,
    input logic [12:0] o_corner_tl, input logic [12:0] o_corner_tr
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid) else $error("result dropped");
    a_noacc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("request taken while result waits");
    a_stq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> !o_has_quad) else $error("status with quad");
    a_tr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_has_quad |-> o_corner_tr == o_corner_tl + 13'd1)
        else $error("corner mismatch");
endmodule

bind conservative_heightmap_min_downsample chmd_checker u_chk (.*);
